// ===== sv/matp_pkg.sv =====
// ----------------------------------------------------------------------------
// matp_pkg
// Shared types, character codes and hex decode for the address text parser.
// ----------------------------------------------------------------------------
package matp_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned ADDR_BYTES = ADDR_W / 8;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DIG_W    = 2;

  localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LC_F  = 8'h66;  // 'f'
  localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UC_F  = 8'h46;  // 'F'
  localparam logic [4:0] NO_HEX     = 5'd16;

  typedef struct packed {
    logic [7:0] text_char;
    logic       final_char;
  } matp_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] mac_address;
    logic              bad_format;
  } matp_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]  octet_index;
    logic [DIG_W-1:0]  digits_in_octet;
    logic [ADDR_W-1:0] address_accumulator;
    logic              error_seen;
    logic              address_complete;
  } matp_state_t;

  // Hex digit value, or NO_HEX for anything else.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
      return v[4:0];
    end
    if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      v = c - CHAR_LC_A + 8'd10;
      return v[4:0];
    end
    if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      v = c - CHAR_UC_A + 8'd10;
      return v[4:0];
    end
    return NO_HEX;
  endfunction

endpackage

// ===== sv/mac_address_text_parser.sv =====
// ----------------------------------------------------------------------------
// mac_address_text_parser
// Streaming parser of colon-separated hex hardware address text.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | matp_in_t  (text_char, final_char)
//   out_    | output    | out_valid/out_ready | matp_out_t (mac_address, bad_format)
//
// One character per cycle while in_ready is high: the parse state register
// closes a loop through the decode and byte insert.
// A result appears in the output register the cycle after its final item.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n low, synchronous) clears the parse state and the result valid.
module mac_address_text_parser #(
  parameter int NUM_OCTETS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  matp_pkg::matp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output matp_pkg::matp_out_t out_data
);
  import matp_pkg::*;

  matp_state_t state_r;
  matp_state_t state_nxt;
  matp_out_t   result;
  matp_out_t   out_data_r;
  logic        out_valid_r;
  logic        in_acc;

  // Output register frees up in the same cycle it is taken.
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  matp_step #(
    .NUM_OCTETS (NUM_OCTETS)
  ) u_step (
    .cur_state (state_r),
    .char_in   (in_data),
    .nxt_state (state_nxt),
    .result    (result)
  );

  // Parse state: only moves on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // Result register: loaded on a final item, held until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_data.final_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.final_char) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/matp_step.sv =====
// ----------------------------------------------------------------------------
// matp_step
// Next parse state for one character, plus the result seen on a final one.
// ----------------------------------------------------------------------------
module matp_step #(
  parameter int NUM_OCTETS = 6
) (
  input  matp_pkg::matp_state_t cur_state,
  input  matp_pkg::matp_in_t    char_in,
  output matp_pkg::matp_state_t nxt_state,
  output matp_pkg::matp_out_t   result
);
  import matp_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_OCTETS - 1);

  logic [4:0]  hex_d;
  logic        is_last;
  logic        end_last;
  logic        bad;
  matp_state_t st;

  assign hex_d   = hex_value(char_in.text_char);
  assign is_last = (cur_state.octet_index >= LAST_IDX);

  always_comb begin
    st = cur_state;
    if (!(cur_state.error_seen || cur_state.address_complete)) begin
      if (hex_d == NO_HEX) begin
        if (cur_state.digits_in_octet == '0) begin
          st.error_seen = 1'b1;
        end else if (is_last) begin
          st.address_complete = 1'b1;
        end else if (char_in.text_char == CHAR_COLON) begin
          st.octet_index     = cur_state.octet_index + 1'b1;
          st.digits_in_octet = '0;
        end else begin
          st.error_seen = 1'b1;
        end
      end else if (cur_state.digits_in_octet >= 2'd2) begin
        st.error_seen = 1'b1;
      end else begin
        // octets above the accumulator's top byte drop off
        for (int k = 0; k < ADDR_BYTES; k++) begin
          if ((NUM_OCTETS - 1 - k >= 0) &&
              (cur_state.octet_index == IDX_W'(NUM_OCTETS - 1 - k))) begin
            st.address_accumulator[8*k +: 8] =
              {cur_state.address_accumulator[8*k +: 4], hex_d[3:0]};
          end
        end
        st.digits_in_octet = cur_state.digits_in_octet + 1'b1;
        if (is_last && st.digits_in_octet == 2'd2) begin
          st.address_complete = 1'b1;
        end
      end
    end
  end

  assign end_last = (st.octet_index >= LAST_IDX) && (st.digits_in_octet != '0);
  assign bad      = st.error_seen || (!st.address_complete && !end_last);

  assign result.bad_format  = bad;
  assign result.mac_address = bad ? '0 : st.address_accumulator;

  // a final character returns the parser to its reset state
  assign nxt_state = char_in.final_char ? '0 : st;

endmodule

// ===== sv/matp_checker.sv =====
// ----------------------------------------------------------------------------
// matp_checker
// Port-level checks on the address text parser, bound to the top level.
// ----------------------------------------------------------------------------
module matp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input matp_pkg::matp_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input matp_pkg::matp_out_t out_data
);
  import matp_pkg::*;

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a bad string never carries an address
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_format |-> out_data.mac_address == '0)
    else $error("address set on bad format");

  // a new result only follows an accepted final item
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.final_char))
    else $error("result without final item");

  // with no result held, the input is always open
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a non-final item raises no result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready && in_data.final_char) |=> !out_valid)
    else $error("result without cause");

endmodule

bind mac_address_text_parser matp_checker u_matp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/mac_address_text_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_tb
// Self-checking bench for the hex address text parser. A short directed table
// covers the character extremes and each kind of malformed text. Random
// strings follow: mostly well-formed addresses with trailing junk, some with
// corruption, some pure noise. Every random result is checked against a
// cycle-free parser model, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module mac_address_text_parser_tb;
  import matp_pkg::*;

  localparam int NUM_OCTS    = 6;
  localparam int ITEM_TARGET = 1200;
  localparam int IDLE_LIMIT  = 1000;  // cycles with no item moving on either side

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  matp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  matp_out_t out_data;

  mac_address_text_parser #(
    .NUM_OCTETS(NUM_OCTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Parser model: mirrors the block's state, advanced once per accepted item.
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]  pr_octet = '0;
  logic [DIG_W-1:0]  pr_digits = '0;
  logic [ADDR_W-1:0] pr_accum = '0;
  logic              pr_error = 1'b0;
  logic              pr_done = 1'b0;

  matp_out_t expected_addresses[$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        in_burst = 1'b0;   // sender runs without gaps while set
  bit        out_burst = 1'b0;  // receiver starts no new stalls while set
  int        hold_left = 0;
  int        idle_cycles = 0;

  // Hex digit decode; returns 0 for anything that is not 0-9, a-f or A-F.
  function automatic bit decode_hex_digit(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] t;
    t = 8'd0;
    v = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      t = c - CHAR_LC_A + 8'd10;
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      t = c - CHAR_UC_A + 8'd10;
    end else begin
      return 1'b0;
    end
    v = t[3:0];
    return 1'b1;
  endfunction

  task automatic parse_step(input matp_in_t d, output bit has_result,
                            output matp_out_t res);
    logic [3:0] nib;
    logic [7:0] old_byte;
    bit         is_hex;
    bit         on_last;
    bit         bad;
    int         sh;
    is_hex = decode_hex_digit(d.text_char, nib);
    on_last = (int'(pr_octet) >= NUM_OCTS - 1);
    has_result = 1'b0;
    res = '0;
    // once errored or complete, characters are ignored until the end of string
    if (!(pr_error || pr_done)) begin
      if (!is_hex) begin
        if (pr_digits == 0) begin
          pr_error = 1'b1;              // no digit where one is needed
        end else if (on_last) begin
          pr_done = 1'b1;               // last octet closed by any non-hex
        end else if (d.text_char == CHAR_COLON) begin
          pr_octet = pr_octet + 1'b1;
          pr_digits = '0;
        end else begin
          pr_error = 1'b1;              // junk inside an inner octet
        end
      end else if (pr_digits >= 2) begin
        pr_error = 1'b1;                // third digit in an inner octet
      end else begin
        sh = 8 * (NUM_OCTS - 1 - int'(pr_octet));
        if (sh >= 0 && sh < ADDR_W) begin
          old_byte = pr_accum[sh +: 8];
          pr_accum[sh +: 8] = {old_byte[3:0], nib};
        end
        pr_digits = pr_digits + 1'b1;
        if (on_last && pr_digits == 2) pr_done = 1'b1;
      end
    end
    if (d.final_char) begin
      bad = pr_error;
      if (!bad && !pr_done) begin
        if (!(int'(pr_octet) >= NUM_OCTS - 1 && pr_digits >= 1)) bad = 1'b1;
      end
      has_result = 1'b1;
      res.mac_address = bad ? '0 : pr_accum;
      res.bad_format = bad;
      pr_octet = '0;
      pr_digits = '0;
      pr_accum = '0;
      pr_error = 1'b0;
      pr_done = 1'b0;
    end
  endtask

  // Gap lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int p;
    p = $urandom_range(0, 21);
    if (p < 10) return CHAR_ZERO + 8'(p);
    if (p < 16) return CHAR_LC_A + 8'(p - 10);
    return CHAR_UC_A + 8'(p - 16);
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at a rising edge. Valid is only
  // lowered when a gap follows, so it is never dropped and raised in one step.
  // A pinned item carries its expected result from the table instead of the
  // model's, though the model is still stepped to keep its state in line.
  // --------------------------------------------------------------------------
  task automatic send_char(input matp_in_t d, input bit pinned, input matp_out_t want);
    bit        has_result;
    matp_out_t res;
    int        gap;
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    parse_step(d, has_result, res);
    if (has_result) expected_addresses.push_back(pinned ? want : res);
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sends a whole string, the final flag on its last character.
  task automatic send_text(input logic [7:0] txt[$], input bit pinned,
                           input matp_out_t want);
    matp_in_t d;
    for (int i = 0; i < txt.size(); i++) begin
      d.text_char = txt[i];
      d.final_char = (i == txt.size() - 1);
      send_char(d, pinned, want);
    end
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic drain_results();
    if (expected_addresses.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_addresses.size() != 0) @(posedge clk);
    end
  endtask

  // Builds one random string: well-formed, corrupted, or noise.
  task automatic build_random_text(output logic [7:0] txt[$]);
    int kind;
    int n;
    int pos;
    txt.delete();
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      for (int o = 0; o < NUM_OCTS; o++) begin
        n = $urandom_range(1, 2);
        repeat (n) txt.push_back(rand_hex_char());
        if (o < NUM_OCTS - 1) txt.push_back(CHAR_COLON);
      end
      // trailing characters: hex may still extend a one-digit last octet
      n = $urandom_range(0, 3);
      repeat (n) txt.push_back($urandom_range(0, 1) ? rand_hex_char()
                                                    : 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 20);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0:       txt.push_back(rand_hex_char());
          1:       txt.push_back(CHAR_COLON);
          default: txt.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end
    if (kind == 6 || kind == 7) begin
      pos = $urandom_range(0, txt.size() - 1);
      case ($urandom_range(0, 3))
        0: txt[pos] = 8'($urandom_range(0, 255));
        1: if (txt.size() > 1) txt.delete(pos);
        2: txt.insert(pos, rand_hex_char());
        default: begin
          n = $urandom_range(1, txt.size());
          while (txt.size() > n) void'(txt.pop_back());
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, with occasional stretches of none.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!out_burst && $urandom_range(0, 3) == 0) hold_left <= pick_gap();
    end
    if ($urandom_range(0, 199) == 0) out_burst <= !out_burst;
  end

  // Result check and watchdog, both on the pre-edge values.
  always @(posedge clk) begin
    matp_out_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_addresses.size() == 0) begin
          $error("unexpected result: mac_address %h bad_format %b",
                 out_data.mac_address, out_data.bad_format);
          mismatches++;
        end else begin
          want = expected_addresses.pop_front();
          if (out_data.mac_address !== want.mac_address) begin
            $error("mac_address mismatch: expected %h, actual %h",
                   want.mac_address, out_data.mac_address);
            mismatches++;
          end
          if (out_data.bad_format !== want.bad_format) begin
            $error("bad_format mismatch: expected %b, actual %b",
                   want.bad_format, out_data.bad_format);
            mismatches++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table: each row is one string. An empty text sends the raw byte
  // alone as a final item (for the character extremes).
  // --------------------------------------------------------------------------
  typedef struct {
    string       text;
    logic [7:0]  raw;
    bit          pinned;
    logic [47:0] addr;
    bit          bad;
  } text_row_t;

  text_row_t dir_rows[6];

  initial begin
    logic [7:0] txt[$];
    matp_out_t  want;
    int         strings_done;
    dir_rows = '{
      '{"",                  8'h00, 1'b1, 48'h0,            1'b1},  // nul, no digit
      '{"",                  8'hFF, 1'b1, 48'h0,            1'b1},  // top byte, no digit
      '{"A",                 8'h00, 1'b1, 48'h0,            1'b1},  // ends too early
      '{"9g",                8'h00, 1'b1, 48'h0,            1'b1},  // junk in inner octet
      '{"0f1",               8'h00, 1'b1, 48'h0,            1'b1},  // three-digit octet
      '{"FF:ff:00:9a:AF:09", 8'h00, 1'b1, 48'hFFFF009AAF09, 1'b0}   // both cases, extremes
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      txt.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) txt.push_back(dir_rows[r].text[i]);
      if (txt.size() == 0) txt.push_back(dir_rows[r].raw);
      want.mac_address = dir_rows[r].addr;
      want.bad_format = dir_rows[r].bad;
      send_text(txt, dir_rows[r].pinned, want);
    end
    drain_results();

    // random strings, with a full hold-off every so often
    strings_done = 0;
    while (items_sent < ITEM_TARGET) begin
      in_burst = ($urandom_range(0, 4) == 0);
      build_random_text(txt);
      send_text(txt, 1'b0, '0);
      strings_done++;
      if (strings_done % 15 == 0) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_addresses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/matp_pkg.sv
sv/matp_step.sv
sv/mac_address_text_parser.sv
sv/matp_checker.sv
tb/mac_address_text_parser_tb.sv
